[rtl/core/postfix_eval_stack_queue_heap_core_defines.svh]
// Assertion macros shared by the evaluator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef POSTFIX_EVAL_STACK_QUEUE_HEAP_CORE_DEFINES_SVH
`define POSTFIX_EVAL_STACK_QUEUE_HEAP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PESQH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PESQH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PESQH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PESQH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/pesqh_pkg.sv]
// Shared constants, datapath step codes and control structs of the evaluator.
// No dependencies.
package pesqh_pkg;

    localparam int STORE_DEPTH_DEF = 64;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;
    localparam logic [2:0] OP_REPORT = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DIVZERO   = 2'd3;

    localparam logic [1:0] SEL_STK  = 2'd0;
    localparam logic [1:0] SEL_QUE  = 2'd1;
    localparam logic [1:0] SEL_HEAP = 2'd2;

    typedef enum logic [4:0] {
        STEP_NONE,
        STEP_LOAD,
        STEP_ERR_FULL,
        STEP_ERR_UF,
        STEP_PUSH_WR,
        STEP_UP_ROOT,
        STEP_UP_RD,
        STEP_UP_CMP,
        STEP_DN_RD0,
        STEP_DN_TOP,
        STEP_DN_LAST,
        STEP_DN_RDL,
        STEP_DN_CMPL,
        STEP_DN_CMPR,
        STEP_DN_FIN,
        STEP_OP_RD1,
        STEP_OP_RD2,
        STEP_OP_LAT,
        STEP_SAVE_HX,
        STEP_SAVE_HY,
        STEP_ALU,
        STEP_DIV_GO,
        STEP_DIV_SAVE,
        STEP_WB,
        STEP_REP_RD,
        STEP_REP_LAT,
        STEP_REP_OUT,
        STEP_REP_ZERO
    } t_step;

    typedef struct packed {
        t_step      step;
        logic [1:0] sel;
        logic [2:0] op;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic lt2;
        logic empty;
        logic hidx_zero;
        logic up_stop;
        logic l_ok;
        logic dn_stop;
        logic div_done;
    } t_stat;

endpackage

[rtl/core/pesqh_ifs.sv]
// Valid/ready channel interfaces for token words in and report words out.
// No dependencies.
interface pesqh_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] value;
    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

interface pesqh_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] stack_result;
    logic signed [31:0] queue_result;
    logic signed [31:0] heap_result;
    logic [1:0]         status;
    modport source (output valid, output stack_result, output queue_result,
                    output heap_result, output status, input ready);
    modport sink (input valid, input stack_result, input queue_result,
                  input heap_result, input status, output ready);
endinterface

[rtl/core/pesqh_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
module pesqh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/pesqh_div.sv]
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// Uses the assertion macros header.
`include "postfix_eval_stack_queue_heap_core_defines.svh"
module pesqh_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_dividend,
    input  logic signed [31:0] i_divisor,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic        r_neg;
    logic [32:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem[31:0], r_quo[31]};
    assign w_ge = w_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend[31] ? 32'(-i_dividend) : i_dividend;
            r_div <= i_divisor[31] ? 32'(-i_divisor) : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sh - {1'b0, r_div} : w_sh;
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    // -2^31 / -1 wraps back to -2^31 through the unsigned magnitude
    assign o_quot = r_neg ? 32'(-r_quo) : r_quo;
    assign o_done = r_done;

    `PESQH_ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "divider restarted")
    `PESQH_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "done while busy")
endmodule

[rtl/core/pesqh_dp.sv]
// Datapath: stack, queue and heap RAMs, heap sift registers, ALU and divider.
// Depends on pesqh_pkg, pesqh_ram, pesqh_div and the assertion macros header.
`include "postfix_eval_stack_queue_heap_core_defines.svh"
module pesqh_dp import pesqh_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic signed [31:0] i_value,
    output t_stat              o_stat,
    output logic signed [31:0] o_stack_result,
    output logic signed [31:0] o_queue_result,
    output logic signed [31:0] o_heap_result,
    output logic [1:0]         o_status
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int LW = AW + 2;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
    localparam logic [LW-1:0] DEPTH_L = LW'(STORE_DEPTH);

    logic [CW-1:0]      r_scount, r_hcount;
    logic [AW-1:0]      r_head, r_hidx;
    logic [1:0]         r_sticky;
    logic signed [31:0] r_vin, r_sx, r_sy, r_qx, r_qy, r_hx, r_hy;
    logic signed [31:0] r_htop, r_val, r_cmin, r_rs, r_rq, r_rh;
    logic               r_cl;

    logic          s_we, q_we, h_we;
    logic [AW-1:0] s_waddr, s_raddr, q_waddr, q_raddr, h_waddr, h_raddr;
    logic [31:0]   s_wdata, s_rdata, q_wdata, q_rdata, h_wdata, h_rdata;

    logic [LW-1:0]      w_lidx, w_ridx;
    logic               w_l_ok, w_r_ok, w_up_stop, w_rt, w_dn_stop, w_x_zero;
    logic [AW-1:0]      w_par, w_stop1, w_stop2, w_qtail, w_qnext1, w_qnext2;
    logic signed [31:0] w_y, w_x, w_alu, w_quot;
    logic               w_div_done;

    function automatic logic [AW-1:0] wrap(input logic [LW-1:0] s);
        return (s >= DEPTH_L) ? AW'(s - DEPTH_L) : AW'(s);
    endfunction

    assign w_lidx    = {1'b0, r_hidx, 1'b1};
    assign w_ridx    = w_lidx + LW'(1);
    assign w_l_ok    = w_lidx < LW'(r_hcount);
    assign w_r_ok    = w_ridx < LW'(r_hcount);
    assign w_par     = AW'((r_hidx - AW'(1)) >> 1);
    assign w_up_stop = $signed(h_rdata) <= r_val;
    assign w_rt      = w_r_ok && ($signed(h_rdata) < r_cmin);
    assign w_dn_stop = !r_cl && !w_rt;
    assign w_stop1   = AW'(r_scount - CW'(1));
    assign w_stop2   = AW'(r_scount - CW'(2));
    assign w_qtail   = wrap(LW'(r_head) + LW'(r_scount));
    assign w_qnext1  = wrap(LW'(r_head) + LW'(1));
    assign w_qnext2  = wrap(LW'(r_head) + LW'(2));

    always_comb begin
        unique case (i_cmd.sel)
            SEL_STK: begin
                w_y = r_sy;
                w_x = r_sx;
            end
            SEL_QUE: begin
                w_y = r_qy;
                w_x = r_qx;
            end
            default: begin
                w_y = r_hy;
                w_x = r_hx;
            end
        endcase
    end
    assign w_x_zero = (w_x == 32'sd0);

    always_comb begin
        unique case (i_cmd.op)
            OP_SUB:  w_alu = w_y - w_x;
            OP_MUL:  w_alu = w_y * w_x;
            default: w_alu = w_y + w_x;
        endcase
    end

    // stack and queue ports
    assign s_we    = (i_cmd.step == STEP_PUSH_WR) || (i_cmd.step == STEP_WB);
    assign s_waddr = (i_cmd.step == STEP_WB) ? w_stop2 : AW'(r_scount);
    assign s_wdata = (i_cmd.step == STEP_WB) ? r_rs : r_vin;
    assign s_raddr = (i_cmd.step == STEP_OP_RD2) ? w_stop2 : w_stop1;
    assign q_we    = s_we;
    assign q_waddr = w_qtail;
    assign q_wdata = (i_cmd.step == STEP_WB) ? r_rq : r_vin;
    assign q_raddr = (i_cmd.step == STEP_OP_RD2) ? w_qnext1 : r_head;

    always_comb begin
        h_we    = 1'b0;
        h_waddr = r_hidx;
        h_wdata = r_val;
        unique case (i_cmd.step)
            STEP_UP_ROOT: begin
                h_we    = 1'b1;
                h_waddr = '0;
            end
            STEP_UP_CMP: begin
                h_we    = 1'b1;
                h_wdata = w_up_stop ? r_val : h_rdata;
            end
            STEP_DN_FIN: h_we = 1'b1;
            STEP_DN_CMPR: begin
                h_we    = 1'b1;
                h_wdata = w_dn_stop ? r_val : (w_rt ? h_rdata : r_cmin);
            end
            default: h_we = 1'b0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.step)
            STEP_DN_RD0:  h_raddr = '0;
            STEP_DN_TOP:  h_raddr = AW'(r_hcount - CW'(1));
            STEP_DN_RDL:  h_raddr = AW'(w_lidx);
            STEP_DN_CMPL: h_raddr = AW'(w_ridx);
            default:      h_raddr = w_par;
        endcase
    end

    pesqh_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_stk_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );
    pesqh_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_que_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );
    pesqh_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_heap_ram (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    pesqh_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.step == STEP_DIV_GO),
        .i_dividend(w_y), .i_divisor(w_x), .o_done(w_div_done), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scount <= '0;
            r_hcount <= '0;
            r_head   <= '0;
            r_sticky <= ST_OK;
        end else begin
            unique case (i_cmd.step)
                STEP_ERR_FULL: if (r_sticky == ST_OK) r_sticky <= ST_FULL;
                STEP_ERR_UF:   if (r_sticky == ST_OK) r_sticky <= ST_UNDERFLOW;
                STEP_DIV_SAVE: if (r_sticky == ST_OK && w_x_zero) r_sticky <= ST_DIVZERO;
                STEP_PUSH_WR: begin
                    r_scount <= r_scount + CW'(1);
                    r_hcount <= r_hcount + CW'(1);
                end
                STEP_DN_TOP: r_hcount <= r_hcount - CW'(1);
                STEP_WB: begin
                    r_scount <= r_scount - CW'(1);
                    r_hcount <= r_hcount + CW'(1);
                    r_head   <= w_qnext2;
                end
                STEP_REP_LAT: begin
                    r_scount <= r_scount - CW'(1);
                    r_head   <= w_qnext1;
                end
                STEP_REP_OUT, STEP_REP_ZERO: r_sticky <= ST_OK;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.step)
            STEP_LOAD: r_vin <= i_value;
            STEP_PUSH_WR: begin
                r_val  <= r_vin;
                r_hidx <= AW'(r_hcount);
            end
            STEP_UP_CMP: if (!w_up_stop) r_hidx <= w_par;
            STEP_DN_TOP: r_htop <= h_rdata;
            STEP_DN_LAST: begin
                r_val  <= h_rdata;
                r_hidx <= '0;
            end
            STEP_DN_CMPL: begin
                r_cl   <= $signed(h_rdata) < r_val;
                r_cmin <= ($signed(h_rdata) < r_val) ? h_rdata : r_val;
            end
            STEP_DN_CMPR: if (!w_dn_stop) r_hidx <= w_rt ? AW'(w_ridx) : AW'(w_lidx);
            STEP_OP_RD2, STEP_REP_LAT: begin
                r_sx <= s_rdata;
                r_qx <= q_rdata;
            end
            STEP_OP_LAT: begin
                r_sy <= s_rdata;
                r_qy <= q_rdata;
            end
            STEP_SAVE_HX: r_hx <= r_htop;
            STEP_SAVE_HY: r_hy <= r_htop;
            STEP_ALU, STEP_DIV_SAVE: begin
                unique case (i_cmd.sel)
                    SEL_STK: r_rs <= (i_cmd.step == STEP_ALU) ? w_alu :
                                     (w_x_zero ? 32'sd0 : w_quot);
                    SEL_QUE: r_rq <= (i_cmd.step == STEP_ALU) ? w_alu :
                                     (w_x_zero ? 32'sd0 : w_quot);
                    default: r_rh <= (i_cmd.step == STEP_ALU) ? w_alu :
                                     (w_x_zero ? 32'sd0 : w_quot);
                endcase
            end
            STEP_WB: begin
                r_val  <= r_rh;
                r_hidx <= AW'(r_hcount);
            end
            STEP_REP_OUT: begin
                o_stack_result <= r_sx;
                o_queue_result <= r_qx;
                o_heap_result  <= r_htop;
                o_status       <= r_sticky;
            end
            STEP_REP_ZERO: begin
                o_stack_result <= '0;
                o_queue_result <= '0;
                o_heap_result  <= '0;
                o_status       <= (r_sticky == ST_OK) ? ST_UNDERFLOW : r_sticky;
            end
            default: ;
        endcase
    end

    assign o_stat.full      = (r_scount == DEPTH_C);
    assign o_stat.lt2       = (r_scount < CW'(2));
    assign o_stat.empty     = (r_scount == '0);
    assign o_stat.hidx_zero = (r_hidx == '0);
    assign o_stat.up_stop   = w_up_stop;
    assign o_stat.l_ok      = w_l_ok;
    assign o_stat.dn_stop   = w_dn_stop;
    assign o_stat.div_done  = w_div_done;

    `PESQH_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, i_cmd.step == STEP_PUSH_WR, r_scount < DEPTH_C, "push into full store")
    `PESQH_ASSERT_IMPL(a_pop_heap, i_clk, i_rst_n, i_cmd.step == STEP_DN_TOP, r_hcount != '0, "pop from empty heap")
    `PESQH_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, i_cmd.step == STEP_NONE, r_scount <= DEPTH_C, "count beyond depth")
endmodule

[rtl/core/pesqh_ctrl.sv]
// Controller: sequences each token word through datapath steps.
// Depends on pesqh_pkg and the assertion macros header.
`include "postfix_eval_stack_queue_heap_core_defines.svh"
module pesqh_ctrl import pesqh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_in_op,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_PUSH, S_UP_CHK, S_UP_CMP, S_DN_RD0, S_DN_TOP, S_DN_LAST,
        S_DN_CHK, S_DN_L, S_DN_R, S_POP_DONE, S_OP_RD2, S_OP_LAT, S_CALC,
        S_DIV_WAIT, S_WB, S_REP_LAT, S_REP_WAIT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [1:0] r_sel, n_sel;
    logic       r_npop, n_npop;
    logic       r_empty, n_empty;
    logic       r_out_valid, n_out_valid;
    logic       w_is_arith;

    assign w_is_arith = (i_in_op == OP_ADD) || (i_in_op == OP_SUB) ||
                        (i_in_op == OP_MUL) || (i_in_op == OP_DIV);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sel       = r_sel;
        n_npop      = r_npop;
        n_empty     = r_empty;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.step  = STEP_NONE;
        o_cmd.sel   = r_sel;
        o_cmd.op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_in_op;
                    if (i_in_op == OP_PUSH) begin
                        if (i_stat.full) begin
                            o_cmd.step = STEP_ERR_FULL;
                        end else begin
                            o_cmd.step = STEP_LOAD;
                            n_state    = S_PUSH;
                        end
                    end else if (w_is_arith) begin
                        if (i_stat.lt2) begin
                            o_cmd.step = STEP_ERR_UF;
                        end else begin
                            o_cmd.step = STEP_OP_RD1;
                            n_npop     = 1'b0;
                            n_state    = S_OP_RD2;
                        end
                    end else if (i_in_op == OP_REPORT) begin
                        n_empty = i_stat.empty;
                        if (i_stat.empty) begin
                            n_state = S_REP_WAIT;
                        end else begin
                            o_cmd.step = STEP_REP_RD;
                            n_state    = S_REP_LAT;
                        end
                    end
                end
            end
            S_PUSH: begin
                o_cmd.step = STEP_PUSH_WR;
                n_state    = S_UP_CHK;
            end
            S_UP_CHK: begin
                if (i_stat.hidx_zero) begin
                    o_cmd.step = STEP_UP_ROOT;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.step = STEP_UP_RD;
                    n_state    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.step = STEP_UP_CMP;
                n_state    = i_stat.up_stop ? S_IDLE : S_UP_CHK;
            end
            S_DN_RD0: begin
                o_cmd.step = STEP_DN_RD0;
                n_state    = S_DN_TOP;
            end
            S_DN_TOP: begin
                o_cmd.step = STEP_DN_TOP;
                n_state    = S_DN_LAST;
            end
            S_DN_LAST: begin
                o_cmd.step = STEP_DN_LAST;
                n_state    = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (i_stat.l_ok) begin
                    o_cmd.step = STEP_DN_RDL;
                    n_state    = S_DN_L;
                end else begin
                    o_cmd.step = STEP_DN_FIN;
                    n_state    = S_POP_DONE;
                end
            end
            S_DN_L: begin
                o_cmd.step = STEP_DN_CMPL;
                n_state    = S_DN_R;
            end
            S_DN_R: begin
                o_cmd.step = STEP_DN_CMPR;
                n_state    = i_stat.dn_stop ? S_POP_DONE : S_DN_CHK;
            end
            S_POP_DONE: begin
                if (r_op == OP_REPORT) begin
                    n_state = S_REP_WAIT;
                end else if (!r_npop) begin
                    o_cmd.step = STEP_SAVE_HX;
                    n_npop     = 1'b1;
                    n_state    = S_DN_RD0;
                end else begin
                    o_cmd.step = STEP_SAVE_HY;
                    n_sel      = SEL_STK;
                    n_state    = S_CALC;
                end
            end
            S_OP_RD2: begin
                o_cmd.step = STEP_OP_RD2;
                n_state    = S_OP_LAT;
            end
            S_OP_LAT: begin
                o_cmd.step = STEP_OP_LAT;
                n_state    = S_DN_RD0;
            end
            S_CALC: begin
                if (r_op == OP_DIV) begin
                    o_cmd.step = STEP_DIV_GO;
                    n_state    = S_DIV_WAIT;
                end else begin
                    o_cmd.step = STEP_ALU;
                    n_sel      = (r_sel == SEL_HEAP) ? SEL_STK : r_sel + 2'd1;
                    n_state    = (r_sel == SEL_HEAP) ? S_WB : S_CALC;
                end
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.step = STEP_DIV_SAVE;
                    n_sel      = (r_sel == SEL_HEAP) ? SEL_STK : r_sel + 2'd1;
                    n_state    = (r_sel == SEL_HEAP) ? S_WB : S_CALC;
                end
            end
            S_WB: begin
                o_cmd.step = STEP_WB;
                n_state    = S_UP_CHK;
            end
            S_REP_LAT: begin
                o_cmd.step = STEP_REP_LAT;
                n_state    = S_DN_RD0;
            end
            S_REP_WAIT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.step  = r_empty ? STEP_REP_ZERO : STEP_REP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_PUSH;
            r_sel       <= SEL_STK;
            r_npop      <= 1'b0;
            r_empty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_sel       <= n_sel;
            r_npop      <= n_npop;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `PESQH_ASSERT_IMPL(a_rep_slot, i_clk, i_rst_n, (o_cmd.step == STEP_REP_OUT) || (o_cmd.step == STEP_REP_ZERO), !r_out_valid || i_out_ready, "report overwrote pending word")
    `PESQH_ASSERT_IMPL(a_div_op, i_clk, i_rst_n, o_cmd.step == STEP_DIV_GO, r_op == OP_DIV, "divider started for other op")
    `PESQH_ASSERT_NEXT(a_rep_valid, i_clk, i_rst_n, (o_cmd.step == STEP_REP_OUT) || (o_cmd.step == STEP_REP_ZERO), r_out_valid, "report word not presented")
endmodule

[rtl/core/postfix_eval_stack_queue_heap_core.sv]
// Postfix evaluator over a stack, a queue and a min-heap, one token word at a time.
// A push writes the word to the stack and queue and sifts it up the heap. An
// operator reads the stack and queue operands, pops the heap twice, computes each
// store's result in the ALU, writes back and sifts up; divide uses instead the
// one-bit-per-cycle divider shared by all three stores, one store after another.
// A report reads stack and queue and pops the heap. The heap walk is bound by the
// registered RAM read: each level step waits for its read data before the compare.
// Depends on pesqh_pkg, pesqh_ifs, pesqh_ctrl and pesqh_dp.
module postfix_eval_stack_queue_heap_core import pesqh_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pesqh_in_if.sink     i_in,
    pesqh_out_if.source  o_out
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;

    pesqh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    pesqh_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (i_in.value),
        .o_stat         (w_stat),
        .o_stack_result (o_out.stack_result),
        .o_queue_result (o_out.queue_result),
        .o_heap_result  (o_out.heap_result),
        .o_status       (o_out.status)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
endmodule

[verif/postfix_eval_stack_queue_heap_core_test.sv]
// Self-checking testbench for the postfix evaluator core: directed table, fill test, random RPN.
// Expectations come from a behavioral stack/queue/heap predictor, or from the table row that gives them.
// Depends on pesqh_pkg, pesqh_ifs and postfix_eval_stack_queue_heap_core.
`timescale 1ns / 100ps

module postfix_eval_stack_queue_heap_core_test;
    import pesqh_pkg::*;

    localparam int DEPTH       = STORE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 400;
    localparam int RAND_ITEMS  = 2000;
    localparam int HOLD_CYCLES = 600;
    localparam logic signed [31:0] VMIN = 32'sh8000_0000;
    localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [31:0] stk;
        logic signed [31:0] que;
        logic signed [31:0] hp;
        logic [1:0]         st;
    } t_report;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] value;
        bit                 typed;
        t_report            rep;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    pesqh_in_if  in_if ();
    pesqh_out_if out_if ();

    postfix_eval_stack_queue_heap_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // predictor state
    logic signed [31:0] stk_vals[$];
    logic signed [31:0] que_vals[$];
    logic signed [31:0] heap_vals[$];
    logic [1:0]         sticky;

    t_report reports_due[$];
    int      mismatches;
    int      reports_seen;
    int      cycles;

    function automatic logic signed [31:0] apply_op(logic [2:0] op, logic signed [31:0] y,
                                                    logic signed [31:0] x);
        longint q;
        case (op)
            OP_ADD: return y + x;
            OP_SUB: return y - x;
            OP_MUL: return y * x;
            default: begin
                if (x == 0) begin
                    if (sticky == ST_OK) sticky = ST_DIVZERO;
                    return 0;
                end
                q = longint'(y) / longint'(x);
                return q[31:0];
            end
        endcase
    endfunction

    function automatic logic signed [31:0] heap_take_min();
        int m;
        logic signed [31:0] v;
        m = 0;
        for (int i = 1; i < heap_vals.size(); i++)
            if (heap_vals[i] < heap_vals[m]) m = i;
        v = heap_vals[m];
        heap_vals.delete(m);
        return v;
    endfunction

    // returns 1 when the word produces a report
    function automatic bit evaluate_token(logic [2:0] op, logic signed [31:0] value,
                                          output t_report rep);
        logic signed [31:0] x, y;
        bit empty;
        rep = '{0, 0, 0, ST_OK};
        case (op)
            OP_PUSH: begin
                if (stk_vals.size() >= DEPTH) begin
                    if (sticky == ST_OK) sticky = ST_FULL;
                end else begin
                    stk_vals.push_back(value);
                    que_vals.push_back(value);
                    heap_vals.push_back(value);
                end
                return 0;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (stk_vals.size() < 2) begin
                    if (sticky == ST_OK) sticky = ST_UNDERFLOW;
                    return 0;
                end
                x = stk_vals.pop_back();
                y = stk_vals.pop_back();
                stk_vals.push_back(apply_op(op, y, x));
                x = que_vals.pop_front();
                y = que_vals.pop_front();
                que_vals.push_back(apply_op(op, y, x));
                x = heap_take_min();
                y = heap_take_min();
                heap_vals.push_back(apply_op(op, y, x));
                return 0;
            end
            OP_REPORT: begin
                empty = (stk_vals.size() == 0);
                if (!empty) begin
                    rep.stk = stk_vals.pop_back();
                    rep.que = que_vals.pop_front();
                    rep.hp  = heap_take_min();
                end else if (sticky == ST_OK) begin
                    sticky = ST_UNDERFLOW;
                end
                rep.st = sticky;
                sticky = ST_OK;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_token(logic [2:0] op, logic signed [31:0] value,
                              bit typed = 0, t_report typed_rep = '{0, 0, 0, ST_OK});
        int gap;
        t_report rep;
        gap = $urandom_range(0, 4);
        if (($urandom_range(0, 7) == 0) || gap == 0) gap = 0;
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.op    = op;
        in_if.value = value;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        if (evaluate_token(op, value, rep))
            reports_due.push_back(typed ? typed_rep : rep);
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VMIN;
            1: return VMAX;
            2: return 0;
            3: return -1;
            4: return 1;
            5, 6: return $signed($urandom_range(0, 40)) - 20;
            default: return $signed($urandom);
        endcase
    endfunction

    // receiver: random stalls, one long hold-off so the core backs up
    initial begin
        int wait_cyc;
        bit held;
        held = 0;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && reports_seen >= 5) begin
                held = 1;
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            wait_cyc = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 4);
            if (wait_cyc > 0) begin
                out_if.ready = 1'b0;
                repeat (wait_cyc) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    // report checker
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            reports_seen++;
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report word: stk=%0d que=%0d heap=%0d st=%0d",
                             out_if.stack_result, out_if.queue_result,
                             out_if.heap_result, out_if.status);
            end else begin
                want = reports_due.pop_front();
                if (out_if.stack_result !== want.stk || out_if.queue_result !== want.que ||
                    out_if.heap_result !== want.hp || out_if.status !== want.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report %0d: exp stk=%0d que=%0d heap=%0d st=%0d, got stk=%0d que=%0d heap=%0d st=%0d",
                                 reports_seen, want.stk, want.que, want.hp, want.st,
                                 out_if.stack_result, out_if.queue_result,
                                 out_if.heap_result, out_if.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** postfix_eval_stack_queue_heap_core: FAILED **");
            $finish;
        end
    end

    t_row rows[$];

    function automatic void add_row(logic [2:0] op, logic signed [31:0] value, bit typed = 0,
                                    logic signed [31:0] s = 0, logic signed [31:0] q = 0,
                                    logic signed [31:0] h = 0, logic [1:0] st = ST_OK);
        t_row r;
        r.op = op; r.value = value; r.typed = typed; r.rep = '{s, q, h, st};
        rows.push_back(r);
    endfunction

    initial begin
        int depth, to_push, remaining;
        logic [2:0] op;
        mismatches   = 0;
        reports_seen = 0;
        cycles       = 0;
        sticky       = ST_OK;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.op     = OP_PUSH;
        in_if.value  = 0;

        // report on empty stores right after reset
        add_row(OP_REPORT, 0, 1, 0, 0, 0, ST_UNDERFLOW);
        // one subtract: the queue sees the operands in the opposite order to the stack and heap
        add_row(OP_PUSH, 7);
        add_row(OP_PUSH, -3);
        add_row(OP_SUB, 0);
        add_row(OP_REPORT, 0, 1, 10, -10, 10, ST_OK);
        // operator on empty stores, sticky underflow
        add_row(OP_ADD, 0);
        add_row(OP_REPORT, 0, 1, 0, 0, 0, ST_UNDERFLOW);
        // divide overflow
        add_row(OP_PUSH, VMIN);
        add_row(OP_PUSH, -1);
        add_row(OP_DIV, 0);
        add_row(OP_REPORT, 0, 1, VMIN, 0, 0, ST_OK);
        // divide by zero
        add_row(OP_PUSH, 5);
        add_row(OP_PUSH, 0);
        add_row(OP_DIV, 0);
        add_row(OP_REPORT, 0, 1, 0, 0, 0, ST_DIVZERO);
        // add wraps
        add_row(OP_PUSH, VMAX);
        add_row(OP_PUSH, 1);
        add_row(OP_ADD, 0);
        add_row(OP_REPORT, 0, 1, VMIN, VMIN, VMIN, ST_OK);
        add_row(OP_PUSH, 3);
        add_row(OP_PUSH, -4);
        add_row(OP_MUL, 0);
        add_row(OP_REPORT, 0);
        // unused codes change nothing
        add_row(3'd6, VMAX);
        add_row(3'd7, -1);
        add_row(OP_REPORT, 0, 1, 0, 0, 0, ST_UNDERFLOW);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i])
            send_token(rows[i].op, rows[i].value, rows[i].typed, rows[i].rep);

        // fill past the top, then drain
        for (int i = 0; i <= DEPTH; i++) send_token(OP_PUSH, pick_value());
        for (int i = 0; i <= DEPTH; i++) send_token(OP_REPORT, 0);

        // random: mostly well-formed expressions, some noise
        remaining = RAND_ITEMS;
        while (remaining > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                send_token(3'($urandom_range(0, 7)), $signed($urandom));
                remaining--;
            end else begin
                to_push = $urandom_range(1, 6);
                depth = 0;
                while (to_push > 0 || depth > 1) begin
                    if (to_push > 0 && (depth < 2 || $urandom_range(0, 1))) begin
                        send_token(OP_PUSH, pick_value());
                        to_push--;
                        depth++;
                    end else begin
                        op = 3'($urandom_range(OP_ADD, OP_DIV));
                        send_token(op, $signed($urandom));
                        depth--;
                    end
                    remaining--;
                end
                send_token(OP_REPORT, $signed($urandom));
                remaining--;
            end
        end
        in_if.valid = 1'b0;

        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && reports_due.size() == 0)
            $display("** postfix_eval_stack_queue_heap_core: PASSED **");
        else
            $display("** postfix_eval_stack_queue_heap_core: FAILED **");
        $finish;
    end

endmodule
